@@ hw/rtl/kaf_pkg.sv @@
// Shared types and constants for the keypad auto-repeat scanner with key FIFO.
package kaf_pkg;

    localparam int KEY_COUNT = 8;
    localparam int LEFT_KEYS = 4;
    localparam int KEY_W     = 8;
    localparam int TIME_W    = 16;
    localparam int CFG_W     = 15;
    localparam int CMD_W     = 2;
    localparam int CIDX_W    = 2;
    localparam int KIDX_W    = 3;

    // Command codes carried in s_tuser.
    localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BACK  = 2'd3;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_FIRST_DELAY  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_REPEAT_IVAL  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_RELEASE_HOLD = 2'd2;

    localparam logic [CFG_W-1:0] FIRST_DELAY_RST  = 15'd400;
    localparam logic [CFG_W-1:0] REPEAT_IVAL_RST  = 15'd100;
    localparam logic [CFG_W-1:0] RELEASE_HOLD_RST = 15'd50;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic             flush;
        logic [KEY_W-1:0] code;
    } kaf_ring_ctl_t;

    typedef struct packed {
        logic             empty;
        logic [KEY_W-1:0] rd_data;
    } kaf_ring_sts_t;

endpackage

@@ hw/rtl/kaf_key_ring.sv @@
// Ring FIFO of key codes that drops new codes when full, with registered read.
module kaf_key_ring #(
    parameter int RING_DEPTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  kaf_pkg::kaf_ring_ctl_t ctl,
    output kaf_pkg::kaf_ring_sts_t sts
);
    import kaf_pkg::*;

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);

    logic [KEY_W-1:0] mem [RING_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_inc, rd_inc;
    logic [KEY_W-1:0] rd_data_reg;
    logic             full, empty;
    logic             do_write;

    assign wr_inc   = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_inc   = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
    // One slot stays unused so that full and empty can be told apart.
    assign full     = (wr_inc == rd_ptr_reg);
    assign empty    = (wr_ptr_reg == rd_ptr_reg);
    assign do_write = ctl.push && !full;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_write)
        begin
            wr_ptr_next = wr_inc;
        end
        if (ctl.flush)
        begin
            rd_ptr_next = wr_ptr_reg;
        end
        else if (ctl.pop && !empty)
        begin
            rd_ptr_next = rd_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wr_ptr_reg] <= ctl.code;
        end
        if (ctl.pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign sts.empty   = empty;
    assign sts.rd_data = rd_data_reg;

endmodule

@@ hw/rtl/keypad_autorepeat_fifo.sv @@
// Top level of the eight-key pad scanner with auto-repeat, release hold and key FIFO.
//
//  Channel   Dir  Signals                       Contents
//  s_axis    in   s_tvalid s_tready s_tdata     one command request (cmd in s_tuser)
//  m_axis    out  m_tvalid m_tready m_tdata     key code and pressed map per request
//  cfg       in   cfg_we cfg_index cfg_data     delay, interval and release hold
//
//  A scan runs a setup step on the shared 16-bit subtract/compare unit, then one
//  step per key for the eight keys, then the final step. A get from the FIFO adds
//  a read-wait step for the registered ring read; a get served by the push-back
//  slot or an empty FIFO, a flush and a push back go straight to the final step.
//  A result waits in the output register; a stalled m_tready holds the block in
//  its final step. Reset clears key state, FIFO pointers and the push-back slot.
module keypad_autorepeat_fifo #(
    parameter int RING_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] time_ms, [19:16] left_levels, [23:20] right_levels, [31:24] key_back
    input  logic [31:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] key_code, [15:8] pressed_map, [16] none_pressed, [23:17] zero
    output logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);
    import kaf_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_KEY   = 3'd2;
    localparam logic [2:0] ST_GETW  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    localparam logic [KIDX_W-1:0] LAST_KEY = KIDX_W'(KEY_COUNT - 1);

    logic [2:0]           state_reg, state_next;
    logic [KIDX_W-1:0]    key_idx_reg, key_idx_next;
    logic [CFG_W-1:0]     frd_reg, frd_next;
    logic [CFG_W-1:0]     ri_reg, ri_next;
    logic [CFG_W-1:0]     rh_reg, rh_next;
    logic [KEY_COUNT-1:0] held_reg, held_next;
    logic [TIME_W-1:0]    rep_stamp_reg [KEY_COUNT];
    logic [TIME_W-1:0]    rep_stamp_next [KEY_COUNT];
    logic [TIME_W-1:0]    seen_stamp_reg [KEY_COUNT];
    logic [TIME_W-1:0]    seen_stamp_next [KEY_COUNT];
    logic [KEY_W-1:0]     pb_reg, pb_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [KEY_COUNT-1:0] down_reg, down_next;
    logic [TIME_W-1:0]    neg_off_reg, neg_off_next;
    logic [KEY_W-1:0]     code_reg, code_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [16:0]          out_reg, out_next;

    logic                 in_accept;
    logic                 cur_down, cur_held, first_press;
    logic [TIME_W-1:0]    unit_a, unit_b, unit_res;
    logic [CFG_W-1:0]     unit_thr;
    logic                 unit_ge;
    kaf_ring_ctl_t        ring_ctl;
    kaf_ring_sts_t        ring_sts;

    kaf_key_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) u_ring (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ring_ctl),
        .sts  (ring_sts)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign cur_down    = down_reg[key_idx_reg];
    assign cur_held    = held_reg[key_idx_reg];
    assign first_press = cur_down && !cur_held;

    // Shared unit: one 16-bit wraparound subtract and one compare with a register.
    // The setup step forms interval - delay, so a first press stamp is t minus it.
    always_comb
    begin
        if (state_reg == ST_SETUP)
        begin
            unit_a = {1'b0, ri_reg};
            unit_b = {1'b0, frd_reg};
        end
        else
        begin
            unit_a = time_reg;
            if (first_press)
            begin
                unit_b = neg_off_reg;
            end
            else if (cur_down)
            begin
                unit_b = rep_stamp_reg[key_idx_reg];
            end
            else
            begin
                unit_b = seen_stamp_reg[key_idx_reg];
            end
        end
        unit_thr = cur_down ? ri_reg : rh_reg;
        unit_res = unit_a - unit_b;
        unit_ge  = !unit_res[TIME_W-1] && (unit_res[CFG_W-1:0] >= unit_thr);
    end

    always_comb
    begin
        state_next      = state_reg;
        key_idx_next    = key_idx_reg;
        frd_next        = frd_reg;
        ri_next         = ri_reg;
        rh_next         = rh_reg;
        held_next       = held_reg;
        rep_stamp_next  = rep_stamp_reg;
        seen_stamp_next = seen_stamp_reg;
        pb_next         = pb_reg;
        time_next       = time_reg;
        down_next       = down_reg;
        neg_off_next    = neg_off_reg;
        code_next       = code_reg;
        out_next        = out_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        ring_ctl        = '0;
        ring_ctl.code   = KEY_W'(key_idx_reg) + KEY_W'(1);

        if (cfg_we)
        begin
            case (cfg_index)
                REG_FIRST_DELAY:  frd_next = cfg_data;
                REG_REPEAT_IVAL:  ri_next  = cfg_data;
                REG_RELEASE_HOLD: rh_next  = cfg_data;
                default:          ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    time_next = s_tdata[15:0];
                    down_next = {~s_tdata[23:20], s_tdata[19:16]};
                    code_next = '0;
                    state_next = ST_FIN;
                    case (s_tuser)
                        CMD_SCAN:
                        begin
                            state_next = ST_SETUP;
                        end
                        CMD_GET:
                        begin
                            if (pb_reg != '0)
                            begin
                                code_next = pb_reg;
                                pb_next   = '0;
                            end
                            else if (!ring_sts.empty)
                            begin
                                ring_ctl.pop = 1'b1;
                                state_next   = ST_GETW;
                            end
                        end
                        CMD_FLUSH:
                        begin
                            ring_ctl.flush = 1'b1;
                            pb_next        = '0;
                        end
                        default:
                        begin
                            pb_next = s_tdata[31:24];
                        end
                    endcase
                end
            end
            ST_SETUP:
            begin
                neg_off_next = unit_res;
                key_idx_next = '0;
                state_next   = ST_KEY;
            end
            ST_KEY:
            begin
                if (cur_down)
                begin
                    if (!cur_held)
                    begin
                        rep_stamp_next[key_idx_reg] = unit_res;
                        held_next[key_idx_reg]      = 1'b1;
                        ring_ctl.push               = 1'b1;
                    end
                    else if (unit_ge)
                    begin
                        rep_stamp_next[key_idx_reg] = time_reg;
                        ring_ctl.push               = 1'b1;
                    end
                    seen_stamp_next[key_idx_reg] = time_reg;
                end
                else if (cur_held && unit_ge)
                begin
                    held_next[key_idx_reg] = 1'b0;
                end
                key_idx_next = key_idx_reg + 1'b1;
                if (key_idx_reg == LAST_KEY)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_GETW:
            begin
                code_next  = ring_sts.rd_data;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next      = {(held_reg == '0), held_reg, code_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            key_idx_reg  <= '0;
            frd_reg      <= FIRST_DELAY_RST;
            ri_reg       <= REPEAT_IVAL_RST;
            rh_reg       <= RELEASE_HOLD_RST;
            held_reg     <= '0;
            pb_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                rep_stamp_reg[i]  <= '0;
                seen_stamp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            key_idx_reg    <= key_idx_next;
            frd_reg        <= frd_next;
            ri_reg         <= ri_next;
            rh_reg         <= rh_next;
            held_reg       <= held_next;
            pb_reg         <= pb_next;
            m_tvalid_reg   <= m_tvalid_next;
            rep_stamp_reg  <= rep_stamp_next;
            seen_stamp_reg <= seen_stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg    <= time_next;
        down_reg    <= down_next;
        neg_off_reg <= neg_off_next;
        code_reg    <= code_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_reg};

    // Codes are queued only while walking the keys.
    a_push_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ring_ctl.push |-> (state_reg == ST_KEY))
        else $error("ring push outside the key walk");

    a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ring_ctl.push && (ring_ctl.pop || ring_ctl.flush)))
        else $error("ring push together with pop or flush");

    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KEY && key_idx_reg == LAST_KEY) |=> (state_reg == ST_FIN))
        else $error("key walk did not end after the last key");

    a_none_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16] == (m_tdata[15:8] == 8'd0)))
        else $error("none_pressed disagrees with pressed_map");

    a_fifo_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ring_ctl.pop |=> (state_reg == ST_GETW))
        else $error("ring read not followed by the read wait step");

endmodule
